// ===== src/strided_view_bounds_checker_assert.svh =====
// Assertion helpers for the strided view bounds checker.
`ifndef STRIDED_VIEW_BOUNDS_CHECKER_ASSERT_SVH
`define STRIDED_VIEW_BOUNDS_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS
`define SVBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svbc assertion failed");
`define SVBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svbc assertion failed");
`else
`define SVBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SVBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/svbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package svbc_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned EtypeW = 3;
  localparam int unsigned StatusW = 2;

  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NO_OWNER = 2'd1;
  localparam logic [StatusW-1:0] STATUS_RANK     = 2'd2;
  localparam logic [StatusW-1:0] STATUS_BOUNDS   = 2'd3;

  localparam logic [EtypeW-1:0] ET_BOOL = 3'd0;
  localparam logic [EtypeW-1:0] ET_U8   = 3'd1;
  localparam logic [EtypeW-1:0] ET_F16  = 3'd2;
  localparam logic [EtypeW-1:0] ET_I32  = 3'd3;
  localparam logic [EtypeW-1:0] ET_U32  = 3'd4;
  localparam logic [EtypeW-1:0] ET_F32  = 3'd5;
  localparam logic [EtypeW-1:0] ET_F64  = 3'd6;

  typedef struct packed {
    logic [HalfW-1:0] mul_a;
    logic [HalfW-1:0] mul_b;
    logic [WordW-1:0] add_a;
    logic [WordW-1:0] add_b;
    logic             add_sub;
  } alu_req_t;

  typedef struct packed {
    logic [WordW-1:0] prod;
    logic [WordW-1:0] sum;
    logic             carry;
  } alu_rsp_t;

  function automatic logic [3:0] elem_bytes(input logic [EtypeW-1:0] code);
    logic [3:0] n;
    case (code)
      ET_BOOL, ET_U8:         n = 4'd1;
      ET_F16:                 n = 4'd2;
      ET_I32, ET_U32, ET_F32: n = 4'd4;
      ET_F64:                 n = 4'd8;
      default:                n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== src/svbc_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared datapath: one 32x32 multiplier and one 64-bit add/subtract.
// On subtract, carry high means no borrow (a >= b).
module svbc_alu (
  input  svbc_pkg::alu_req_t req,
  output svbc_pkg::alu_rsp_t rsp
);

  logic [svbc_pkg::WordW-1:0] b_op;
  logic [svbc_pkg::WordW:0]   wide;

  assign b_op = req.add_sub ? ~req.add_b : req.add_b;
  assign wide = {1'b0, req.add_a} + {1'b0, b_op}
              + {{svbc_pkg::WordW{1'b0}}, req.add_sub};

  assign rsp.prod  = {{svbc_pkg::HalfW{1'b0}}, req.mul_a}
                   * {{svbc_pkg::HalfW{1'b0}}, req.mul_b};
  assign rsp.sum   = wide[svbc_pkg::WordW-1:0];
  assign rsp.carry = wide[svbc_pkg::WordW];

endmodule

`default_nettype wire

// ===== src/strided_view_bounds_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       request    in_valid/in_stall    dimension and view fields
// out      result     out_valid/out_stall  status, first/end byte
//
// A dimension item steps through accept, three 32x32 partial products, combine and
// accumulate, skipping accumulate if the product overflows; an item with no dimension,
// a zero size or a view already in error is only accepted.
// A last item then runs end-address and bound checks on the shared adder.
// rst_n is synchronous, active low; it clears the sums, error flag and out_valid.
// A held result stalls only the final step; the next request is taken meanwhile.
module strided_view_bounds_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic                                in_has_dim,
  input  wire logic [svbc_pkg::WordW-1:0]          in_dim_size,
  input  wire logic signed [svbc_pkg::WordW-1:0]   in_dim_stride,
  input  wire logic                                in_last_dim,
  input  wire logic [svbc_pkg::EtypeW-1:0]         in_elem_type,
  input  wire logic [svbc_pkg::WordW-1:0]          in_view_offset,
  input  wire logic [svbc_pkg::WordW-1:0]          in_alloc_size,
  input  wire logic                                in_owner_present,
  input  wire logic                                in_rank_matches,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [svbc_pkg::StatusW-1:0]        out_status,
  output      logic [svbc_pkg::WordW-1:0]          out_first_byte,
  output      logic [svbc_pkg::WordW-1:0]          out_end_byte
);

  localparam int unsigned W = svbc_pkg::WordW;
  localparam int unsigned H = svbc_pkg::HalfW;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MUL0 = 11'b000_0000_0010,
    S_MUL1 = 11'b000_0000_0100,
    S_MUL2 = 11'b000_0000_1000,
    S_COMB = 11'b000_0001_0000,
    S_ACC  = 11'b000_0010_0000,
    S_OFS  = 11'b000_0100_0000,
    S_ESZ  = 11'b000_1000_0000,
    S_LOW  = 11'b001_0000_0000,
    S_HIGH = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } st_t;

  st_t st_r, st_nxt;

  logic [W-1:0] span_r, span_nxt;
  logic [W-1:0] mag_r, mag_nxt;
  logic         neg_r, neg_nxt;
  logic         last_r, last_nxt;
  logic [svbc_pkg::EtypeW-1:0] et_r, et_nxt;
  logic [W-1:0] off_r, off_nxt;
  logic [W-1:0] alloc_r, alloc_nxt;
  logic         own_r, own_nxt;
  logic         rank_r, rank_nxt;
  logic [W-1:0] below_r, below_nxt;
  logic [W-1:0] above_r, above_nxt;
  logic         bad_r, bad_nxt;
  logic [W-1:0] p0_r, p0_nxt;
  logic [W-1:0] pc_r, pc_nxt;
  logic         hh_r, hh_nxt;
  logic [W-1:0] ext_r, ext_nxt;
  logic [W-1:0] e_r, e_nxt;
  logic [W-1:0] first_r, first_nxt;
  logic         chk_r, chk_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [svbc_pkg::StatusW-1:0] out_status_r, out_status_nxt;
  logic [W-1:0] out_first_r, out_first_nxt;
  logic [W-1:0] out_end_r, out_end_nxt;

  svbc_pkg::alu_req_t alu_req;
  svbc_pkg::alu_rsp_t alu_rsp;

  logic [W-1:0] esz;
  logic [W-1:0] stride_u;
  logic         in_take;
  logic [svbc_pkg::StatusW-1:0] status_c;
  st_t          after_dim;

  svbc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign esz      = {{(W-4){1'b0}}, svbc_pkg::elem_bytes(et_r)};
  assign stride_u = $unsigned(in_dim_stride);
  assign in_stall = (st_r != S_IDLE);
  assign in_take  = in_valid && (st_r == S_IDLE);
  assign after_dim = last_r ? S_OFS : S_IDLE;

  always_comb begin
    if (!own_r) begin
      status_c = svbc_pkg::STATUS_NO_OWNER;
    end else if (!rank_r) begin
      status_c = svbc_pkg::STATUS_RANK;
    end else if (esz == '0 || bad_r || chk_r) begin
      status_c = svbc_pkg::STATUS_BOUNDS;
    end else begin
      status_c = svbc_pkg::STATUS_OK;
    end
  end

  always_comb begin
    alu_req = '0;
    case (st_r)
      S_MUL0: begin
        alu_req.mul_a = span_r[H-1:0];
        alu_req.mul_b = mag_r[H-1:0];
      end
      S_MUL1: begin
        alu_req.mul_a = span_r[W-1:H];
        alu_req.mul_b = mag_r[H-1:0];
      end
      S_MUL2: begin
        alu_req.mul_a = span_r[H-1:0];
        alu_req.mul_b = mag_r[W-1:H];
      end
      S_COMB: begin
        alu_req.add_a = p0_r;
        alu_req.add_b = {pc_r[H-1:0], {H{1'b0}}};
      end
      S_ACC: begin
        alu_req.add_a = neg_r ? below_r : above_r;
        alu_req.add_b = ext_r;
      end
      S_OFS: begin
        alu_req.add_a = off_r;
        alu_req.add_b = above_r;
      end
      S_ESZ: begin
        alu_req.add_a = e_r;
        alu_req.add_b = esz;
      end
      S_LOW: begin
        alu_req.add_a   = off_r;
        alu_req.add_b   = below_r;
        alu_req.add_sub = 1'b1;
      end
      S_HIGH: begin
        alu_req.add_a   = alloc_r;
        alu_req.add_b   = e_r;
        alu_req.add_sub = 1'b1;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    st_nxt         = st_r;
    span_nxt       = span_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    last_nxt       = last_r;
    et_nxt         = et_r;
    off_nxt        = off_r;
    alloc_nxt      = alloc_r;
    own_nxt        = own_r;
    rank_nxt       = rank_r;
    below_nxt      = below_r;
    above_nxt      = above_r;
    bad_nxt        = bad_r;
    p0_nxt         = p0_r;
    pc_nxt         = pc_r;
    hh_nxt         = hh_r;
    ext_nxt        = ext_r;
    e_nxt          = e_r;
    first_nxt      = first_r;
    chk_nxt        = chk_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_end_nxt    = out_end_r;

    case (st_r)
      S_IDLE: begin
        if (in_take) begin
          span_nxt  = in_dim_size - {{(W-1){1'b0}}, 1'b1};
          neg_nxt   = stride_u[W-1];
          mag_nxt   = stride_u[W-1] ? (~stride_u + {{(W-1){1'b0}}, 1'b1}) : stride_u;
          last_nxt  = in_last_dim;
          et_nxt    = in_elem_type;
          off_nxt   = in_view_offset;
          alloc_nxt = in_alloc_size;
          own_nxt   = in_owner_present;
          rank_nxt  = in_rank_matches;
          chk_nxt   = 1'b0;
          if (in_has_dim && !bad_r && in_dim_size != '0) begin
            st_nxt = S_MUL0;
          end else begin
            if (in_has_dim && !bad_r) begin
              bad_nxt = 1'b1;
            end
            st_nxt = in_last_dim ? S_OFS : S_IDLE;
          end
        end
      end
      S_MUL0: begin
        p0_nxt = alu_rsp.prod;
        hh_nxt = (span_r[W-1:H] != '0) && (mag_r[W-1:H] != '0);
        st_nxt = S_MUL1;
      end
      S_MUL1: begin
        pc_nxt = alu_rsp.prod;
        st_nxt = S_MUL2;
      end
      S_MUL2: begin
        // without a high-high term at most one cross product is nonzero
        pc_nxt = pc_r | alu_rsp.prod;
        st_nxt = S_COMB;
      end
      S_COMB: begin
        if (hh_r || pc_r[W-1:H] != '0 || alu_rsp.carry) begin
          bad_nxt = 1'b1;
          st_nxt  = after_dim;
        end else begin
          ext_nxt = alu_rsp.sum;
          st_nxt  = S_ACC;
        end
      end
      S_ACC: begin
        if (alu_rsp.carry) begin
          bad_nxt = 1'b1;
        end else if (neg_r) begin
          below_nxt = alu_rsp.sum;
        end else begin
          above_nxt = alu_rsp.sum;
        end
        st_nxt = after_dim;
      end
      S_OFS: begin
        e_nxt   = alu_rsp.sum;
        chk_nxt = chk_r | alu_rsp.carry;
        st_nxt  = S_ESZ;
      end
      S_ESZ: begin
        e_nxt   = alu_rsp.sum;
        chk_nxt = chk_r | alu_rsp.carry;
        st_nxt  = S_LOW;
      end
      S_LOW: begin
        first_nxt = alu_rsp.sum;
        chk_nxt   = chk_r | !alu_rsp.carry;
        st_nxt    = S_HIGH;
      end
      S_HIGH: begin
        chk_nxt = chk_r | !alu_rsp.carry;
        st_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_c;
          out_first_nxt  = (status_c == svbc_pkg::STATUS_OK) ? first_r : '0;
          out_end_nxt    = (status_c == svbc_pkg::STATUS_OK) ? e_r : '0;
          below_nxt      = '0;
          above_nxt      = '0;
          bad_nxt        = 1'b0;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      below_r     <= '0;
      above_r     <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      below_r     <= below_nxt;
      above_r     <= above_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r       <= span_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    last_r       <= last_nxt;
    et_r         <= et_nxt;
    off_r        <= off_nxt;
    alloc_r      <= alloc_nxt;
    own_r        <= own_nxt;
    rank_r       <= rank_nxt;
    p0_r         <= p0_nxt;
    pc_r         <= pc_nxt;
    hh_r         <= hh_nxt;
    ext_r        <= ext_nxt;
    e_r          <= e_nxt;
    first_r      <= first_nxt;
    chk_r        <= chk_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_end_r    <= out_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_first_byte = out_first_r;
  assign out_end_byte   = out_end_r;

`include "strided_view_bounds_checker_assert.svh"

  `SVBC_ASSERT_IMPL(a_err_zero, clk, rst_n,
                    out_valid && out_status != svbc_pkg::STATUS_OK,
                    out_first_byte == '0 && out_end_byte == '0)
  `SVBC_ASSERT_NEXT(a_nodim_fast, clk, rst_n,
                    in_valid && !in_stall && !in_has_dim && !in_last_dim, !in_stall)
  `SVBC_ASSERT_IMPL(a_out_from_done, clk, rst_n, $rose(out_valid), $past(st_r == S_DONE))

endmodule

`default_nettype wire
